### src/qir_pkg.sv
// ----------------------------------------------------------------------------
// qir_pkg: shared definitions for the quadratic interpolating resampler
// Constants, default parameters and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package qir_pkg;

   // Width and reset value of the phase step register (Q16 source advance).
   localparam int StepW     = 17;
   localparam int ResetStep = 10465;
   localparam int StepMax   = 65536;

   // Source sample format: unsigned 8 bits, silence at mid scale.
   localparam int SampleW    = 8;
   localparam int SampleBias = 128;

   // Output sample format: signed 16 bits, saturated.
   localparam int PcmW   = 16;
   localparam int PcmMax = 32767;
   localparam int PcmMin = -32768;

   // Default fraction width and largest upsampling ratio.
   localparam int DefFracBits    = 16;
   localparam int DefMaxUpsample = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_in;   // capture the incoming transaction
      logic setup;     // load interpolation coefficients for a run
      logic run_b;     // current run is the end-of-sound run (next sample is zero)
      logic mul1;      // first multiply step
      logic mul2;      // second multiply step
      logic emit;      // load the output register and advance the position
      logic shift;     // move the sample history forward by one
      logic clear;     // return the sound history to its reset values
   } qir_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic have_prev;    // at least one sample of this sound is held
      logic last_in;      // captured transaction carries the end-of-sound flag
      logic more;         // another output position remains in this run
      logic cap_reached;  // output count limit for this transaction reached
      logic out_free;     // output register can take a new result this cycle
   } qir_sts_type;

endpackage

### src/qir_stream_if.sv
// ----------------------------------------------------------------------------
// qir_stream_if: valid/ready channels of the resampler
// One interface for incoming source samples and one for output samples.
// ----------------------------------------------------------------------------
interface qir_req_if;
   logic                         valid;
   logic                         ready;
   logic [qir_pkg::SampleW-1:0]  sample;
   logic                         last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface qir_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [qir_pkg::PcmW-1:0] pcm;
   logic                          run_end;
   logic                          sound_end;

   modport source (output valid, output pcm, output run_end, output sound_end, input ready);
   modport sink   (input valid, input pcm, input run_end, input sound_end, output ready);
endinterface

### src/qir_dpath.sv
// ----------------------------------------------------------------------------
// qir_dpath: resampler datapath
// Holds the sample history, output position, step register and the
// interpolation arithmetic, and owns the output register.
// ----------------------------------------------------------------------------
module qir_dpath #(
   parameter int FRAC_BITS    = qir_pkg::DefFracBits,
   parameter int MAX_UPSAMPLE = qir_pkg::DefMaxUpsample
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [qir_pkg::StepW-1:0]         csr_wr_data,
   input  logic [qir_pkg::SampleW-1:0]       in_sample,
   input  logic                              in_last,
   input  qir_pkg::qir_cmd_type              cmd,
   output qir_pkg::qir_sts_type              sts,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [qir_pkg::PcmW-1:0]   rsp_pcm,
   output logic                              rsp_run_end,
   output logic                              rsp_sound_end
);

   localparam int PosW      = FRAC_BITS + 1;
   localparam int CapCount  = 2 * MAX_UPSAMPLE;
   localparam int CntW      = $clog2(CapCount + 1);
   localparam int ShiftUp   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int ShiftDown = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int WideW     = qir_pkg::StepW + ShiftUp;
   localparam int TW        = FRAC_BITS + 11;
   localparam int NW        = 2 * FRAC_BITS + 11;
   localparam int DropBits  = 2 * FRAC_BITS - 7;
   localparam int VW        = NW - DropBits;
   localparam int SW        = qir_pkg::SampleW + 1;

   localparam logic [qir_pkg::StepW-1:0] StepMinVal =
      qir_pkg::StepW'(qir_pkg::StepMax / MAX_UPSAMPLE);
   localparam logic [qir_pkg::StepW-1:0] StepMaxVal = qir_pkg::StepW'(qir_pkg::StepMax);
   localparam logic [CntW-1:0]           CapVal     = CntW'(CapCount);
   localparam logic signed [NW-1:0]      Bias       = NW'((64'd1 << DropBits) - 64'd1);
   localparam logic signed [VW-1:0]      VMax       = VW'(qir_pkg::PcmMax);
   localparam logic signed [VW-1:0]      VMin       = VW'(qir_pkg::PcmMin);

   // Removes the mid-scale offset from an unsigned source sample.
   function automatic logic signed [SW-1:0] center(input logic [qir_pkg::SampleW-1:0] x);
      center = $signed({1'b0, x}) - SW'(qir_pkg::SampleBias);
   endfunction

   logic [qir_pkg::StepW-1:0]         step_ff;
   logic [qir_pkg::SampleW-1:0]       x_ff;
   logic                              last_ff;
   logic [qir_pkg::SampleW-1:0]       newer_ff;
   logic [qir_pkg::SampleW-1:0]       older_ff;
   logic [1:0]                        seen_ff;
   logic [PosW-1:0]                   pos_ff;
   logic [CntW-1:0]                   cnt_ff;
   logic signed [10:0]                coef_a_ff;
   logic signed [9:0]                 coef_b_ff;
   logic signed [SW-1:0]              s1_ff;
   logic signed [TW-1:0]              t_ff;
   logic signed [NW-1:0]              p_ff;
   logic                              rsp_valid_ff;
   logic signed [qir_pkg::PcmW-1:0]   pcm_ff;
   logic                              run_end_ff;
   logic                              sound_end_ff;

   logic [qir_pkg::StepW-1:0]         step_clamped;
   logic [PosW-1:0]                   step_pos;
   logic [PosW-1:0]                   pos_sum;
   logic [CntW-1:0]                   cnt_inc;
   logic                              cap_next;
   logic                              run_end_calc;
   logic signed [SW-1:0]              s0_sel;
   logic signed [SW-1:0]              s1_sel;
   logic signed [SW-1:0]              s2_sel;
   logic signed [10:0]                coef_a_in;
   logic signed [9:0]                 coef_b_in;
   logic signed [TW-1:0]              a_ext;
   logic signed [TW-1:0]              b_ext;
   logic signed [TW-1:0]              f_short;
   logic signed [TW-1:0]              t_in;
   logic signed [NW-1:0]              f_wide;
   logic signed [NW-1:0]              t_wide;
   logic signed [NW-1:0]              p_in;
   logic signed [NW-1:0]              num;
   logic signed [NW-1:0]              num_adj;
   logic signed [VW-1:0]              v_full;
   logic signed [qir_pkg::PcmW-1:0]   pcm_in;

   // Clamp the programmed step and scale it to the position fraction width.
   always_comb begin
      if (step_ff < StepMinVal) begin
         step_clamped = StepMinVal;
      end else if (step_ff > StepMaxVal) begin
         step_clamped = StepMaxVal;
      end else begin
         step_clamped = step_ff;
      end
      step_pos = PosW'((WideW'(step_clamped) << ShiftUp) >> ShiftDown);
   end

   // Position lookahead and output count limit.
   assign pos_sum      = pos_ff + step_pos;
   assign cnt_inc      = cnt_ff + CntW'(1);
   assign cap_next     = (cnt_inc == CapVal);
   assign run_end_calc = cap_next || (pos_sum[FRAC_BITS] && (cmd.run_b || !last_ff));

   // Coefficients of the quadratic in the fraction: a*f^2 + b*f*one + 2*s1*one^2.
   always_comb begin
      s0_sel    = (seen_ff >= 2'd2) ? center(older_ff) : '0;
      s1_sel    = center(newer_ff);
      s2_sel    = cmd.run_b ? '0 : center(x_ff);
      coef_a_in = 11'(s0_sel) - (11'(s1_sel) <<< 1) + 11'(s2_sel);
      coef_b_in = 10'(s2_sel) - 10'(s0_sel);
   end

   // First multiply: t = a*f + b*one.
   always_comb begin
      a_ext   = TW'(coef_a_ff);
      b_ext   = TW'(coef_b_ff);
      f_short = $signed(TW'(pos_ff[FRAC_BITS-1:0]));
      t_in    = a_ext * f_short + (b_ext <<< FRAC_BITS);
   end

   // Second multiply: p = f*t.
   always_comb begin
      f_wide = $signed(NW'(pos_ff[FRAC_BITS-1:0]));
      t_wide = NW'(t_ff);
      p_in   = f_wide * t_wide;
   end

   // Add the centre term, divide with truncation toward zero and saturate.
   // The scale of 256 is folded into the shift amount.
   always_comb begin
      num     = p_ff + (NW'(s1_ff) <<< (2 * FRAC_BITS + 1));
      num_adj = num[NW-1] ? num + Bias : num;
      v_full  = num_adj[NW-1:DropBits];
      if (v_full > VMax) begin
         pcm_in = qir_pkg::PcmW'(qir_pkg::PcmMax);
      end else if (v_full < VMin) begin
         pcm_in = qir_pkg::PcmW'(qir_pkg::PcmMin);
      end else begin
         pcm_in = v_full[qir_pkg::PcmW-1:0];
      end
   end

   // Step register, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= qir_pkg::StepW'(qir_pkg::ResetStep);
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   // Sound history, output position and per-transaction output count.
   always_ff @(posedge clock) begin
      if (reset) begin
         newer_ff <= '0;
         older_ff <= '0;
         seen_ff  <= '0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.take_in) begin
            cnt_ff <= '0;
         end
         if (cmd.emit) begin
            pos_ff <= pos_sum;
            cnt_ff <= cnt_inc;
         end
         if (cmd.shift) begin
            older_ff <= newer_ff;
            newer_ff <= x_ff;
            if (seen_ff != 2'd2) begin
               seen_ff <= seen_ff + 2'd1;
            end
            pos_ff <= pos_ff[FRAC_BITS] ? {1'b0, pos_ff[FRAC_BITS-1:0]} : '0;
         end
         if (cmd.clear) begin
            newer_ff <= '0;
            older_ff <= '0;
            seen_ff  <= '0;
            pos_ff   <= '0;
         end
      end
   end

   // Payload registers of the working transaction and the arithmetic.
   always_ff @(posedge clock) begin
      if (cmd.take_in) begin
         x_ff    <= in_sample;
         last_ff <= in_last;
      end
      if (cmd.setup) begin
         coef_a_ff <= coef_a_in;
         coef_b_ff <= coef_b_in;
         s1_ff     <= s1_sel;
      end
      if (cmd.mul1) begin
         t_ff <= t_in;
      end
      if (cmd.mul2) begin
         p_ff <= p_in;
      end
   end

   // Output register: holds a result until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pcm_ff       <= pcm_in;
         run_end_ff   <= run_end_calc;
         sound_end_ff <= run_end_calc && last_ff;
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.have_prev   = (seen_ff != 2'd0);
      sts.last_in     = last_ff;
      sts.more        = !pos_sum[FRAC_BITS] && !cap_next;
      sts.cap_reached = (cnt_ff == CapVal);
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pcm       = pcm_ff;
   assign rsp_run_end   = run_end_ff;
   assign rsp_sound_end = sound_end_ff;

endmodule

### src/qir_ctrl.sv
// ----------------------------------------------------------------------------
// qir_ctrl: resampler controller
// Sequences one transaction at a time: the run for the held centre sample,
// the history shift and, at the end of a sound, the closing run.
// ----------------------------------------------------------------------------
module qir_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qir_pkg::qir_sts_type sts,
   output qir_pkg::qir_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SETUP_A = 7'b0000010,
      ST_SETUP_B = 7'b0000100,
      ST_MUL1    = 7'b0001000,
      ST_MUL2    = 7'b0010000,
      ST_EMIT    = 7'b0100000,
      ST_SHIFT   = 7'b1000000
   } qir_state_type;

   qir_state_type state_ff;
   qir_state_type state_in;
   logic          run_b_ff;
   logic          run_b_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      run_b_in  = run_b_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.run_b = run_b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_in = 1'b1;
               run_b_in    = 1'b0;
               state_in    = sts.have_prev ? ST_SETUP_A : ST_SHIFT;
            end
         end
         ST_SETUP_A, ST_SETUP_B: begin
            cmd.setup = 1'b1;
            state_in  = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.more) begin
                  state_in = ST_MUL1;
               end else if (run_b_ff) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (sts.last_in && sts.cap_reached) begin
               // Output limit already used up: the sound simply closes.
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.shift = 1'b1;
               if (sts.last_in) begin
                  run_b_in = 1'b1;
                  state_in = ST_SETUP_B;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         run_b_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_b_ff <= run_b_in;
      end
   end

endmodule

### src/quadratic_interp_resampler.sv
// ----------------------------------------------------------------------------
// quadratic_interp_resampler: three-point Lagrange sample rate converter
// Turns a stream of unsigned 8-bit source samples into signed 16-bit output
// samples at positions spaced by a programmable Q16 phase step.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one source sample per transaction, with last_sample set
//    on the final sample of a sound. rsp_chan carries output samples; run_end
//    marks the last output caused by a source sample and sound_end the final
//    output of a sound.
//  - csr_wr_data is the phase step, written when csr_wr_en is high. Write it
//    only while no source sample is in progress.
//  - Each output is made by two multiply steps and the output load; a setup
//    step comes before the first one once its source sample is accepted. A
//    source sample that yields outputs also takes a setup step and a history
//    shift, and the first sample of a sound, which yields none, only the shift. An
//    end-of-sound sample adds a setup step and its closing outputs, and
//    nothing when the output limit is already used up. req_chan.ready is high
//    only while the block waits for input.
//  - Results sit in an output register, so the block takes the next source
//    sample while the last result still waits. If the receiver stalls, the
//    block holds at the next output until the register is free.
//  - Synchronous reset clears the sound history and output register and sets
//    the phase step to its default of 10465.
// ----------------------------------------------------------------------------
module quadratic_interp_resampler #(
   parameter int FRAC_BITS    = qir_pkg::DefFracBits,
   parameter int MAX_UPSAMPLE = qir_pkg::DefMaxUpsample
) (
   input  logic                      clock,
   input  logic                      reset,
   qir_req_if.sink                   req_chan,
   qir_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [qir_pkg::StepW-1:0] csr_wr_data
);

   qir_pkg::qir_cmd_type cmd;
   qir_pkg::qir_sts_type sts;
   logic                 req_ready;
   logic                 rsp_valid;

   // Transaction sequencing.
   qir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic, history and output register.
   qir_dpath #(
      .FRAC_BITS    (FRAC_BITS),
      .MAX_UPSAMPLE (MAX_UPSAMPLE)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .in_sample     (req_chan.sample),
      .in_last       (req_chan.last_sample),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_pcm       (rsp_chan.pcm),
      .rsp_run_end   (rsp_chan.run_end),
      .rsp_sound_end (rsp_chan.sound_end)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // A result is never loaded while the block is waiting for input.
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> !req_ready)
      else $error("output loaded while waiting for input");

   // A result is only loaded when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_chan.ready))
      else $error("output register overwritten");

   // The end of a sound is always the end of a run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chan.sound_end) |-> rsp_chan.run_end)
      else $error("sound_end without run_end");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

### dv/quadratic_interp_resampler_test.sv
// ----------------------------------------------------------------------------
// quadratic_interp_resampler_test: self-checking testbench for the resampler
// Sends sounds of unsigned 8-bit samples through the request channel and
// predicts every interpolated output sample in the testbench itself. Each
// output transaction is checked field by field against the oldest
// prediction. The run covers the default, extreme and out-of-range phase
// steps, output saturation, the output count cap, a sender pause until the
// output drains, and random sounds under three idling patterns.
// ----------------------------------------------------------------------------
module quadratic_interp_resampler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FracBits    = qir_pkg::DefFracBits;
   localparam int MaxUpsample = qir_pkg::DefMaxUpsample;
   localparam int StepMin     = qir_pkg::StepMax / MaxUpsample;
   localparam int MaxPerItem  = 2 * MaxUpsample;
   localparam int SettleCycles  = 24;
   localparam int WatchdogLimit = 2000;

   // One expected output transaction.
   typedef struct packed {
      logic signed [qir_pkg::PcmW-1:0] pcm;
      logic                            run_end;
      logic                            sound_end;
   } pcm_result_type;

   logic clock;
   logic reset;
   logic                      csr_wr_en;
   logic [qir_pkg::StepW-1:0] csr_wr_data;

   qir_req_if req_if();
   qir_rsp_if rsp_if();

   quadratic_interp_resampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Idle percentages of the sender and the receiver.
   int unsigned tx_idle_pct;
   int unsigned rx_idle_pct;
   int unsigned fail_count;
   int unsigned quiet_cycles;

   // Predictor state: the phase step register and the sound history.
   logic [qir_pkg::StepW-1:0]       step_reg;
   int                              held_new;
   int                              held_old;
   int                              held_count;
   longint                          next_pos;
   logic signed [qir_pkg::PcmW-1:0] item_pcm[$];
   pcm_result_type                  expected_pcm_q[$];
   pcm_result_type                  oldest;

   // Clock generation.
   always #10 clock = ~clock;

   // Phase step as used: clamped to the legal range and scaled to FracBits.
   function automatic longint effective_step();
      longint s;
      s = longint'(step_reg);
      if (s < StepMin) s = StepMin;
      if (s > qir_pkg::StepMax) s = qir_pkg::StepMax;
      if (FracBits >= 16) return s << (FracBits - 16);
      return s >> (16 - FracBits);
   endfunction

   // Three-point Lagrange value at fraction frac, scaled by 256 and saturated.
   function automatic logic signed [qir_pkg::PcmW-1:0] lagrange_point(
      longint s0, longint s1, longint s2, longint frac);
      longint one_pos;
      longint num;
      longint v;
      one_pos = longint'(1) << FracBits;
      num = s0 * frac * (frac - one_pos) - 2 * s1 * (frac * frac - one_pos * one_pos)
            + s2 * (frac + one_pos) * frac;
      v = num / (longint'(1) << (2 * FracBits - 7));
      if (v > qir_pkg::PcmMax) v = qir_pkg::PcmMax;
      if (v < qir_pkg::PcmMin) v = qir_pkg::PcmMin;
      return v[qir_pkg::PcmW-1:0];
   endfunction

   // Emits every output position that falls on the current centre sample, up to the per-item output limit.
   function automatic void run_positions(longint s0, longint s1, longint s2);
      longint step;
      step = effective_step();
      while (next_pos < (longint'(1) << FracBits) && item_pcm.size() < MaxPerItem) begin
         item_pcm.push_back(lagrange_point(s0, s1, s2, next_pos));
         next_pos += step;
      end
   endfunction

   // Updates the sound history with one accepted sample and queues its outputs.
   function automatic void predict_outputs(int x, logic last);
      longint s0;
      longint s1;
      int n;
      pcm_result_type r;
      item_pcm.delete();
      if (held_count >= 1) begin
         s0 = (held_count >= 2) ? longint'(held_old - qir_pkg::SampleBias) : 0;
         s1 = longint'(held_new - qir_pkg::SampleBias);
         run_positions(s0, s1, longint'(x - qir_pkg::SampleBias));
         if (next_pos >= (longint'(1) << FracBits)) next_pos -= longint'(1) << FracBits;
         else next_pos = 0;
      end
      held_old = held_new;
      held_new = x;
      if (held_count < 2) held_count++;

      // The end of a sound closes the last centre with a zero neighbour.
      if (last) begin
         s0 = (held_count >= 2) ? longint'(held_old - qir_pkg::SampleBias) : 0;
         run_positions(s0, longint'(held_new - qir_pkg::SampleBias), 0);
         held_new = 0;
         held_old = 0;
         held_count = 0;
         next_pos = 0;
      end
      n = item_pcm.size();
      for (int i = 0; i < n; i++) begin
         r.pcm = item_pcm[i];
         r.run_end = (i == n - 1);
         r.sound_end = last && (i == n - 1);
         expected_pcm_q.push_back(r);
      end
   endfunction

   // Tracks register writes and accepted samples, and checks each output.
   always @(posedge clock) begin
      if (reset) begin
         step_reg = qir_pkg::StepW'(qir_pkg::ResetStep);
         held_new = 0;
         held_old = 0;
         held_count = 0;
         next_pos = 0;
      end else begin
         if (csr_wr_en) step_reg = csr_wr_data;
         if (req_if.valid && req_if.ready)
            predict_outputs(int'(req_if.sample), req_if.last_sample);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pcm_q.size() == 0) begin
               $error("unexpected output transaction: pcm %0d run_end %0b sound_end %0b",
                      rsp_if.pcm, rsp_if.run_end, rsp_if.sound_end);
               fail_count++;
            end else begin
               oldest = expected_pcm_q.pop_front();
               if (rsp_if.pcm !== oldest.pcm) begin
                  $error("pcm: expected %0d, actual %0d", oldest.pcm, rsp_if.pcm);
                  fail_count++;
               end
               if (rsp_if.run_end !== oldest.run_end) begin
                  $error("run_end: expected %0b, actual %0b", oldest.run_end, rsp_if.run_end);
                  fail_count++;
               end
               if (rsp_if.sound_end !== oldest.sound_end) begin
                  $error("sound_end: expected %0b, actual %0b",
                         oldest.sound_end, rsp_if.sound_end);
                  fail_count++;
               end
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Watchdog: too many cycles without any transaction ends the run.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Sends one source sample; called and returns at a falling edge.
   task automatic send_sample(input int x, input bit last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= x[qir_pkg::SampleW-1:0];
      req_if.last_sample <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops sending and waits until every predicted output has arrived.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_pcm_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes the phase step register while the block is idle.
   task automatic write_phase_step(input int unsigned value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[qir_pkg::StepW-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly random bytes, with the full-scale values now and then.
   function automatic int random_sample();
      case ($urandom_range(7))
         0: return 0;
         1: return 255;
         default: return $urandom_range(255);
      endcase
   endfunction

   // Short sounds at the reset step, including a single-sample sound.
   task automatic test_default_step();
      send_sample(255, 1);
      send_sample(0, 0);
      send_sample(255, 0);
      send_sample(0, 0);
      send_sample(128, 1);
   endtask

   // Largest, smallest and out-of-range steps; the smallest hits the count cap.
   task automatic test_step_extremes();
      write_phase_step(qir_pkg::StepMax);
      send_sample(17, 0);
      send_sample(200, 1);
      write_phase_step(StepMin);
      send_sample(40, 0);
      send_sample(230, 1);
      write_phase_step(0);
      send_sample(128, 1);
      write_phase_step((1 << qir_pkg::StepW) - 1);
      send_sample(5, 0);
      send_sample(250, 1);
   endtask

   // Half-sample positions between full-scale samples overflow 16 bits.
   task automatic test_saturation();
      write_phase_step(qir_pkg::StepMax / 2);
      send_sample(255, 0);
      send_sample(0, 0);
      send_sample(0, 0);
      send_sample(0, 1);
      send_sample(0, 0);
      send_sample(255, 0);
      send_sample(255, 0);
      send_sample(255, 1);
   endtask

   // The sender holds off in the middle of a sound until the output drains.
   task automatic test_pause_mid_sound();
      for (int i = 0; i < 3; i++) send_sample(random_sample(), 0);
      wait_drained();
      for (int i = 0; i < 3; i++) send_sample(random_sample(), i == 2);
   endtask

   // Random sounds of random length at the given step.
   task automatic test_random_sounds(input int unsigned items, input int unsigned step);
      int unsigned sent;
      int unsigned len;
      write_phase_step(step);
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
         for (int unsigned i = 0; i < len; i++) send_sample(random_sample(), i == len - 1);
         sent += len;
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      req_if.last_sample = 1'b0;
      rsp_if.ready = 1'b0;
      fail_count = 0;
      quiet_cycles = 0;
      tx_idle_pct = 26;
      rx_idle_pct = 88;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_step();
      test_step_extremes();
      test_saturation();
      test_random_sounds(80, $urandom_range(StepMin, qir_pkg::StepMax));

      // Sender slow, receiver mostly ready; any 17-bit step.
      wait_drained();
      tx_idle_pct = 88;
      rx_idle_pct = 26;
      test_pause_mid_sound();
      test_random_sounds(80, $urandom_range((1 << qir_pkg::StepW) - 1));

      // Back-to-back traffic on both sides.
      wait_drained();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_sounds(80, 7042 * 65536 / 22050);

      wait_drained();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
